>>> rtl/wfp_pkg.sv
// ----------------------------------------------------------------------------
// wfp_pkg
// Types, constants and arithmetic helpers of the waypoint follower.
// ----------------------------------------------------------------------------
package wfp_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int WP_AW = $clog2(MAX_WAYPOINTS);
	localparam int WP_CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int IN_DW = 160;
	localparam int OUT_DW = 200;
	localparam int OUT_UW = 2;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_LIN_GAIN    = 3'd0,
		REG_ROT_GAIN    = 3'd1,
		REG_MAX_LIN_VEL = 3'd2,
		REG_MAX_ROT_VEL = 3'd3,
		REG_ARRIVE_THR  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] lin_gain;
		logic [15:0] rot_gain;
		logic [30:0] max_lin_vel;
		logic [30:0] max_rot_vel;
		logic [30:0] arrive_thr;
	} cfg_t;

	// index 0 x, 1 y, 2 z, 3 w
	typedef struct packed {
		op_t              op;
		logic             path_end;
		logic [2:0][31:0] pos;
		logic [3:0][15:0] quat;
	} item_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][15:0] quat;
	} wp_t;

	localparam int WP_W = $bits(wp_t);

	typedef struct packed {
		logic [2:0][31:0] lin;
		logic [2:0][31:0] ang;
		logic [5:0]       goal_index;
		logic             path_active;
		logic             path_done;
	} res_t;

	function automatic logic [31:0] sat(input logic signed [61:0] v, input logic [30:0] lim);
		logic signed [61:0] l;
		begin
			l = $signed({31'b0, lim});
			if (v > l) begin
				sat = 32'(l);
			end else if (v < -l) begin
				sat = 32'(-l);
			end else begin
				sat = 32'(v);
			end
		end
	endfunction

	function automatic logic [41:0] abs42(input logic signed [41:0] v);
		abs42 = v[41] ? 42'(-v) : 42'(v);
	endfunction

endpackage

>>> rtl/waypoint_follow_p_controller_top.sv
// ----------------------------------------------------------------------------
// waypoint_follow_p_controller_top
// Waypoint follower with proportional velocity control.
// ----------------------------------------------------------------------------
// channel  dir  word
// s_axis   in   tdata: pos_x pos_y pos_z quat_x..quat_w; tuser kind; tlast path_end
// m_axis   out  tdata: lin_x..ang_z goal_index; tuser path_active path_done
// cfg      in   cfg_index register, cfg_data value; always ready
//
// A load word is taken while the execution side is idle; a tick runs 31
// steps on the shared multiplier, a goal fetch when the goal moves and a
// state to post the result. A two-word queue sits in front.
// Reset clears the path, goal and registers to defaults; the waypoint
// memory needs no clearing. A stalled m_axis holds the next tick at its end.
// ----------------------------------------------------------------------------
module waypoint_follow_p_controller_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [wfp_pkg::IN_DW-1:0]   s_axis_tdata,  // pos_x pos_y pos_z quat_x quat_y quat_z quat_w
	input  logic                        s_axis_tuser,  // kind
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [wfp_pkg::OUT_DW-1:0]  m_axis_tdata,  // lin_x lin_y lin_z ang_x ang_y ang_z goal_index
	output logic [wfp_pkg::OUT_UW-1:0]  m_axis_tuser,  // path_active path_done
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wfp_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [wfp_pkg::CFG_DW-1:0]  cfg_data
);
	import wfp_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;
	res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_gain    <= 16'd256;
			cfg_q.rot_gain    <= 16'd1280;
			cfg_q.max_lin_vel <= 31'd19661;
			cfg_q.max_rot_vel <= 31'd327680;
			cfg_q.arrive_thr  <= 31'd3277;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIN_GAIN:    cfg_q.lin_gain    <= cfg_data[15:0];
				REG_ROT_GAIN:    cfg_q.rot_gain    <= cfg_data[15:0];
				REG_MAX_LIN_VEL: cfg_q.max_lin_vel <= cfg_data[30:0];
				REG_MAX_ROT_VEL: cfg_q.max_rot_vel <= cfg_data[30:0];
				REG_ARRIVE_THR:  cfg_q.arrive_thr  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	wfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.s_tlast (s_axis_tlast),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	wfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (res)
	);

	assign m_axis_tdata = {2'b00, res.goal_index, res.ang, res.lin};
	assign m_axis_tuser = {res.path_done, res.path_active};
endmodule

>>> rtl/wfp_ram.sv
// ----------------------------------------------------------------------------
// wfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/wfp_front.sv
// ----------------------------------------------------------------------------
// wfp_front
// Input side: unpacks stream words, classifies them and queues two deep.
// ----------------------------------------------------------------------------
module wfp_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [wfp_pkg::IN_DW-1:0] s_tdata,
	input  logic                      s_tuser,
	input  logic                      s_tlast,
	output logic                      q_valid,
	input  logic                      q_ready,
	output wfp_pkg::item_t            q_item
);
	import wfp_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       push;
	logic       pop;

	always_comb begin
		in_item.op       = s_tuser ? OP_TICK : OP_LOAD;
		in_item.path_end = s_tlast;
		in_item.pos      = s_tdata[95:0];
		in_item.quat     = s_tdata[159:96];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

>>> rtl/wfp_back.sv
// ----------------------------------------------------------------------------
// wfp_back
// Execution side: path storage, control law on a shared multiplier, goal update.
// ----------------------------------------------------------------------------
module wfp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wfp_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  wfp_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output wfp_pkg::res_t  out_res
);
	import wfp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_QUAT,
		MS_MAT,
		MS_LIN,
		MS_ANG
	} msel_t;

	typedef struct packed {
		msel_t      sel;
		logic [1:0] a;
		logic [1:0] b;
	} op_dec_t;

	localparam logic [4:0] S_BUILD_M = 5'd11;
	localparam logic [4:0] S_D       = 5'd22;
	localparam logic [4:0] S_LAST    = 5'd30;

	function automatic op_dec_t dec_step(input logic [4:0] s);
		op_dec_t r;
		begin
			r = '{sel: MS_NONE, a: 2'd0, b: 2'd0};
			unique case (s)
				5'd0:  r = '{sel: MS_QUAT, a: 2'd0, b: 2'd0};
				5'd1:  r = '{sel: MS_QUAT, a: 2'd1, b: 2'd1};
				5'd2:  r = '{sel: MS_QUAT, a: 2'd2, b: 2'd2};
				5'd3:  r = '{sel: MS_QUAT, a: 2'd3, b: 2'd3};
				5'd4:  r = '{sel: MS_QUAT, a: 2'd0, b: 2'd1};
				5'd5:  r = '{sel: MS_QUAT, a: 2'd0, b: 2'd2};
				5'd6:  r = '{sel: MS_QUAT, a: 2'd1, b: 2'd2};
				5'd7:  r = '{sel: MS_QUAT, a: 2'd3, b: 2'd0};
				5'd8:  r = '{sel: MS_QUAT, a: 2'd3, b: 2'd1};
				5'd9:  r = '{sel: MS_QUAT, a: 2'd3, b: 2'd2};
				5'd12: r = '{sel: MS_MAT, a: 2'd0, b: 2'd0};
				5'd13: r = '{sel: MS_MAT, a: 2'd0, b: 2'd1};
				5'd14: r = '{sel: MS_MAT, a: 2'd0, b: 2'd2};
				5'd15: r = '{sel: MS_MAT, a: 2'd1, b: 2'd0};
				5'd16: r = '{sel: MS_MAT, a: 2'd1, b: 2'd1};
				5'd17: r = '{sel: MS_MAT, a: 2'd1, b: 2'd2};
				5'd18: r = '{sel: MS_MAT, a: 2'd2, b: 2'd0};
				5'd19: r = '{sel: MS_MAT, a: 2'd2, b: 2'd1};
				5'd20: r = '{sel: MS_MAT, a: 2'd2, b: 2'd2};
				5'd23: r = '{sel: MS_LIN, a: 2'd0, b: 2'd0};
				5'd24: r = '{sel: MS_LIN, a: 2'd1, b: 2'd0};
				5'd25: r = '{sel: MS_LIN, a: 2'd2, b: 2'd0};
				5'd26: r = '{sel: MS_ANG, a: 2'd0, b: 2'd0};
				5'd27: r = '{sel: MS_ANG, a: 2'd1, b: 2'd0};
				5'd28: r = '{sel: MS_ANG, a: 2'd2, b: 2'd0};
				default: r = '{sel: MS_NONE, a: 2'd0, b: 2'd0};
			endcase
			dec_step = r;
		end
	endfunction

	state_t              state_q;
	logic [4:0]          step_q;
	item_t               item_q;
	logic signed [32:0]  e_q [3];
	logic signed [61:0]  prod_q;
	logic [4:0]          tag_q;
	logic                tag_v_q;
	logic signed [31:0]  qp_q [10];
	logic signed [19:0]  m_q [3][3];
	logic signed [55:0]  acc_q [3];
	logic signed [41:0]  d_q [3];
	logic [31:0]         cmd_q [6];
	logic [2:0][31:0]    goal_pos_q;
	logic [2:0][15:0]    goal_quat_q;
	logic [WP_AW-1:0]    goal_idx_q;
	logic [WP_AW-1:0]    fetch_idx_q;
	logic [WP_CW-1:0]    count_q;
	logic                path_ready_q;
	logic                following_q;
	logic                finished_q;
	logic                out_valid_q;
	res_t                out_res_q;

	op_dec_t             iss;
	op_dec_t             con;
	logic signed [41:0]  mul_a;
	logic signed [19:0]  mul_b;
	logic signed [34:0]  qe [10];
	logic signed [34:0]  msum [3][3];
	logic [43:0]         err;
	logic                adv;
	logic                start;
	logic                arrive;
	logic                last_wp;
	logic                fetch;
	logic                at_end;
	logic [WP_AW-1:0]    next_idx;
	logic                wr_en;
	wp_t                 wr_wp;
	wp_t                 rd_wp;
	logic                push_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign iss       = dec_step(step_q);
	assign con       = dec_step(tag_q);
	assign push_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (iss.sel)
			MS_QUAT: begin
				mul_a = 42'($signed(item_q.quat[iss.a]));
				mul_b = 20'($signed(item_q.quat[iss.b]));
			end
			MS_MAT: begin
				mul_a = 42'(e_q[iss.b]);
				mul_b = m_q[iss.b][iss.a];
			end
			MS_LIN: begin
				mul_a = d_q[iss.a];
				mul_b = $signed({4'b0, cfg.lin_gain});
			end
			MS_ANG: begin
				mul_a = 42'(17'($signed(goal_quat_q[iss.a])) - 17'($signed(item_q.quat[iss.a])));
				mul_b = $signed({4'b0, cfg.rot_gain});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// qp order: xx yy zz ww xy xz yz wx wy wz
	always_comb begin
		for (int k = 0; k < 10; k++) begin
			qe[k] = 35'(qp_q[k]);
		end
		msum[0][0] = qe[3] + qe[0] - qe[1] - qe[2];
		msum[0][1] = (qe[4] - qe[9]) <<< 1;
		msum[0][2] = (qe[5] + qe[8]) <<< 1;
		msum[1][0] = (qe[4] + qe[9]) <<< 1;
		msum[1][1] = qe[3] - qe[0] + qe[1] - qe[2];
		msum[1][2] = (qe[6] - qe[7]) <<< 1;
		msum[2][0] = (qe[5] - qe[8]) <<< 1;
		msum[2][1] = (qe[6] + qe[7]) <<< 1;
		msum[2][2] = qe[3] - qe[0] - qe[1] + qe[2];
	end

	always_comb begin
		err      = 44'(abs42(d_q[0])) + 44'(abs42(d_q[1])) + 44'(abs42(d_q[2]));
		adv      = path_ready_q && (count_q != '0);
		start    = adv && !following_q;
		arrive   = adv && following_q && !finished_q && (err < 44'(cfg.arrive_thr));
		last_wp  = (WP_CW'(goal_idx_q) + WP_CW'(1)) >= count_q;
		fetch    = start || (arrive && !last_wp);
		next_idx = start ? '0 : goal_idx_q + WP_AW'(1);
		at_end   = (state_q == ST_RUN) && (step_q == S_LAST);
		wr_en    = (state_q == ST_IDLE) && in_valid && (in_item.op == OP_LOAD) &&
		           !path_ready_q && (count_q < WP_CW'(MAX_WAYPOINTS));
		wr_wp.pos  = in_item.pos;
		wr_wp.quat = in_item.quat[2:0];
	end

	wfp_ram #(
		.WIDTH(WP_W),
		.DEPTH(MAX_WAYPOINTS)
	) u_wp_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[WP_AW-1:0]),
		.wdata(wr_wp),
		.re   (at_end && fetch),
		.raddr(next_idx),
		.rdata(rd_wp)
	);

	// datapath
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			item_q <= in_item;
			for (int i = 0; i < 3; i++) begin
				e_q[i] <= 33'($signed(goal_pos_q[i])) - 33'($signed(in_item.pos[i]));
			end
		end
		prod_q <= mul_a * mul_b;
		tag_q  <= step_q;
		if (tag_v_q) begin
			unique case (con.sel)
				MS_QUAT: qp_q[tag_q[3:0]] <= 32'(prod_q);
				MS_MAT: begin
					if (con.b == 2'd0) begin
						acc_q[con.a] <= 56'(prod_q);
					end else begin
						acc_q[con.a] <= acc_q[con.a] + 56'(prod_q);
					end
				end
				MS_LIN: cmd_q[con.a] <= sat((prod_q + 62'sd128) >>> 8, cfg.max_lin_vel);
				MS_ANG: cmd_q[3'(con.a) + 3'd3] <= sat((prod_q + 62'sd32) >>> 6, cfg.max_rot_vel);
				default: ;
			endcase
		end
		if ((state_q == ST_RUN) && (step_q == S_BUILD_M)) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					m_q[r][c] <= 20'((msum[r][c] + 35'sd8192) >>> 14);
				end
			end
		end
		if ((state_q == ST_RUN) && (step_q == S_D)) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= 42'((acc_q[i] + 56'sd8192) >>> 14);
			end
		end
		if (at_end) begin
			fetch_idx_q <= next_idx;
		end
		if (push_out) begin
			for (int i = 0; i < 3; i++) begin
				out_res_q.lin[i] <= cmd_q[i];
				out_res_q.ang[i] <= cmd_q[i + 3];
			end
			out_res_q.goal_index  <= 6'(goal_idx_q);
			out_res_q.path_active <= following_q;
			out_res_q.path_done   <= finished_q;
		end
	end

	// control and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			tag_v_q      <= 1'b0;
			count_q      <= '0;
			path_ready_q <= 1'b0;
			following_q  <= 1'b0;
			finished_q   <= 1'b1;
			goal_idx_q   <= '0;
			goal_pos_q   <= '0;
			goal_quat_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			tag_v_q <= (state_q == ST_RUN) && (iss.sel != MS_NONE);
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_item.op == OP_TICK) begin
							state_q <= ST_RUN;
							step_q  <= '0;
						end else if (!path_ready_q) begin
							if (wr_en) begin
								count_q <= count_q + WP_CW'(1);
							end
							if (in_item.path_end) begin
								path_ready_q <= 1'b1;
							end
						end
					end
				end
				ST_RUN: begin
					step_q <= step_q + 5'd1;
					if (at_end) begin
						if (start) begin
							following_q <= 1'b1;
							finished_q  <= 1'b0;
						end else if (arrive && last_wp) begin
							finished_q <= 1'b1;
						end
						state_q <= fetch ? ST_FETCH : ST_OUT;
					end
				end
				ST_FETCH: begin
					goal_idx_q  <= fetch_idx_q;
					goal_pos_q  <= rd_wp.pos;
					goal_quat_q <= rd_wp.quat;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (push_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_follow_needs_path: assert property (@(posedge clk) disable iff (!arst_n)
		following_q |-> path_ready_q) else $error("following without closed path");
	a_unfinished_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q |-> following_q) else $error("active goal while not following");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= WP_CW'(MAX_WAYPOINTS)) else $error("waypoint count overflow");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= S_LAST)) else $error("step past end");
	a_push_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT)) else $error("result pushed early");
endmodule
